>>> design/u8dec_pkg.sv
`timescale 1ns / 1ps

package u8dec_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned POINT_W = 21;

   // lead byte ranges
   localparam logic [7:0] ASCII_LIMIT = 8'h80;
   localparam logic [7:0] LEAD2_MIN   = 8'hC2;
   localparam logic [7:0] LEAD2_MAX   = 8'hDF;
   localparam logic [7:0] LEAD3_MIN   = 8'hE0;
   localparam logic [7:0] LEAD3_MAX   = 8'hEF;
   localparam logic [7:0] LEAD4_MIN   = 8'hF0;
   localparam logic [7:0] LEAD4_MAX   = 8'hF4;

   localparam logic [7:0] CONT_MASK    = 8'hC0;
   localparam logic [7:0] CONT_PATTERN = 8'h80;
   localparam logic [7:0] CONT_PAYLOAD = 8'h3F;

   // smallest legal value for each sequence length, and the scalar limits
   localparam logic [POINT_W-1:0] MIN_LEN2      = 21'h000080;
   localparam logic [POINT_W-1:0] MIN_LEN3      = 21'h000800;
   localparam logic [POINT_W-1:0] MIN_LEN4      = 21'h010000;
   localparam logic [POINT_W-1:0] MAX_POINT     = 21'h10FFFF;
   localparam logic [POINT_W-1:0] SURROGATE_LO  = 21'h00D800;
   localparam logic [POINT_W-1:0] SURROGATE_HI  = 21'h00DFFF;

   // continuation counts of a sequence
   localparam logic [1:0] CONT_NONE  = 2'd0;
   localparam logic [1:0] CONT_ONE   = 2'd1;
   localparam logic [1:0] CONT_TWO   = 2'd2;
   localparam logic [1:0] CONT_THREE = 2'd3;

   localparam logic KIND_VALID   = 1'b0;
   localparam logic KIND_INVALID = 1'b1;

   typedef struct packed {
      logic [1:0]         bytes_pending;
      logic [1:0]         sequence_length;
      logic [POINT_W-1:0] partial_point;
      logic               discarding;
   } u8dec_state_type;

   typedef struct packed {
      logic [POINT_W-1:0] code_point;
      logic               kind;
      logic               last;
   } u8dec_result_type;

endpackage

>>> design/u8dec_req_if.sv
`timescale 1ns / 1ps

interface u8dec_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;
   logic       final_byte;

   modport source (output valid, output byte_in, output final_byte, input ready);
   modport sink (input valid, input byte_in, input final_byte, output ready);
endinterface

>>> design/u8dec_rsp_if.sv
`timescale 1ns / 1ps

interface u8dec_rsp_if;
   logic        valid;
   logic        ready;
   logic [20:0] code_point;
   logic        kind;
   logic        last;

   modport source (output valid, output code_point, output kind, output last, input ready);
   modport sink (input valid, input code_point, input kind, input last, output ready);
endinterface

>>> design/utf8_validating_decoder.sv
`timescale 1ns / 1ps

// UTF-8 validating decoder. Accepts one byte per clock, sustained, and gives at most one
// result per byte: a code point when a sequence completes, or a single invalid result
// (marked last) at the first error of a string, after which the rest of that string up to
// its final byte is dropped. A byte passes an input register, one decode step, and the
// result register, from which its result is presented; the rate of one byte per cycle
// is set by that single decode step updating the sequence state once per byte.
// Back-pressure on the result side stalls both registers, and the input side keeps
// taking a byte while a result waits as long as the input register is free.
module utf8_validating_decoder (
   input  logic        clock,
   input  logic        reset,
   u8dec_req_if.sink   req_bus,
   u8dec_rsp_if.source rsp_bus
);
   import u8dec_pkg::*;

   logic             in_valid_ff, in_valid_in;
   logic [7:0]       in_byte_ff, in_byte_in;
   logic             in_final_ff, in_final_in;
   u8dec_state_type  state_ff, state_in;
   logic             out_valid_ff, out_valid_in;
   u8dec_result_type out_ff, out_in;

   u8dec_state_type  step_state;
   logic             step_emit;
   u8dec_result_type step_result;
   logic             advance;
   logic             fire;

   u8dec_step u_step (
      .state_cur  (state_ff),
      .byte_in    (in_byte_ff),
      .final_byte (in_final_ff),
      .state_nxt  (step_state),
      .emit       (step_emit),
      .result     (step_result)
   );

   always_comb begin
      advance       = ~out_valid_ff | rsp_bus.ready;
      fire          = in_valid_ff & advance;
      req_bus.ready = ~in_valid_ff | advance;

      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_final_in = in_final_ff;
      if (req_bus.ready) begin
         in_valid_in = req_bus.valid;
         in_byte_in  = req_bus.byte_in;
         in_final_in = req_bus.final_byte;
      end

      state_in     = fire ? step_state : state_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (advance) begin
         out_valid_in = fire & step_emit;
         out_in       = step_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      in_final_ff <= in_final_in;
      out_ff      <= out_in;
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.code_point = out_ff.code_point;
   assign rsp_bus.kind       = out_ff.kind;
   assign rsp_bus.last       = out_ff.last;

`ifndef SYNTHESIS
   a_invalid_form: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.kind == KIND_INVALID) |-> (out_ff.last && out_ff.code_point == '0))
      else $error("invalid result without last or with nonzero value");

   a_valid_scalar: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.kind == KIND_VALID) |->
         (out_ff.code_point <= MAX_POINT &&
          (out_ff.code_point < SURROGATE_LO || out_ff.code_point > SURROGATE_HI)))
      else $error("emitted value is not a Unicode scalar");

   a_discard_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff.discarding |-> (state_ff.bytes_pending == CONT_NONE))
      else $error("discarding with a sequence still open");

   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      (fire && in_final_ff) |=> (state_ff.bytes_pending == CONT_NONE && !state_ff.discarding))
      else $error("state not idle after final byte transfer");
`endif

endmodule

>>> design/u8dec_step.sv
`timescale 1ns / 1ps

// One decode step: current state and one byte in, next state and an optional result out.
module u8dec_step (
   input  u8dec_pkg::u8dec_state_type  state_cur,
   input  logic [7:0]                  byte_in,
   input  logic                        final_byte,
   output u8dec_pkg::u8dec_state_type  state_nxt,
   output logic                        emit,
   output u8dec_pkg::u8dec_result_type result
);
   import u8dec_pkg::*;

   logic               err;
   logic [POINT_W-1:0] acc;
   logic [1:0]         pend_dec;
   logic               bad;

   always_comb begin
      acc      = {state_cur.partial_point[POINT_W-7:0], byte_in[5:0]};
      pend_dec = state_cur.bytes_pending - 2'd1;
      bad      = ((state_cur.sequence_length == CONT_ONE) && (acc < MIN_LEN2)) ||
                 ((state_cur.sequence_length == CONT_TWO) && (acc < MIN_LEN3)) ||
                 ((state_cur.sequence_length == CONT_THREE) && (acc < MIN_LEN4)) ||
                 (acc > MAX_POINT) ||
                 ((acc >= SURROGATE_LO) && (acc <= SURROGATE_HI));
   end

   always_comb begin
      state_nxt = state_cur;
      err       = 1'b0;
      emit      = 1'b0;
      result    = '0;
      if (state_cur.discarding) begin
         if (final_byte) begin
            state_nxt.discarding = 1'b0;
         end
      end else if (state_cur.bytes_pending == CONT_NONE) begin
         if (byte_in < ASCII_LIMIT) begin
            emit              = 1'b1;
            result.code_point = {{(POINT_W-BYTE_W){1'b0}}, byte_in};
            result.kind       = KIND_VALID;
            result.last       = final_byte;
         end else if (byte_in >= LEAD2_MIN && byte_in <= LEAD2_MAX) begin
            state_nxt.partial_point   = {{(POINT_W-5){1'b0}}, byte_in[4:0]};
            state_nxt.sequence_length = CONT_ONE;
            state_nxt.bytes_pending   = CONT_ONE;
            err                       = final_byte;
         end else if (byte_in >= LEAD3_MIN && byte_in <= LEAD3_MAX) begin
            state_nxt.partial_point   = {{(POINT_W-4){1'b0}}, byte_in[3:0]};
            state_nxt.sequence_length = CONT_TWO;
            state_nxt.bytes_pending   = CONT_TWO;
            err                       = final_byte;
         end else if (byte_in >= LEAD4_MIN && byte_in <= LEAD4_MAX) begin
            state_nxt.partial_point   = {{(POINT_W-3){1'b0}}, byte_in[2:0]};
            state_nxt.sequence_length = CONT_THREE;
            state_nxt.bytes_pending   = CONT_THREE;
            err                       = final_byte;
         end else begin
            err = 1'b1;
         end
      end else if ((byte_in & CONT_MASK) != CONT_PATTERN) begin
         // the offending byte is consumed, not retried as a lead
         err = 1'b1;
      end else if (pend_dec != CONT_NONE) begin
         state_nxt.partial_point = acc;
         state_nxt.bytes_pending = pend_dec;
         err                     = final_byte;
      end else begin
         state_nxt.bytes_pending   = CONT_NONE;
         state_nxt.sequence_length = CONT_NONE;
         state_nxt.partial_point   = '0;
         if (bad) begin
            err = 1'b1;
         end else begin
            emit              = 1'b1;
            result.code_point = acc;
            result.kind       = KIND_VALID;
            result.last       = final_byte;
         end
      end

      if (err) begin
         state_nxt.bytes_pending   = CONT_NONE;
         state_nxt.sequence_length = CONT_NONE;
         state_nxt.partial_point   = '0;
         state_nxt.discarding      = ~final_byte;
         emit                      = 1'b1;
         result.code_point         = '0;
         result.kind               = KIND_INVALID;
         result.last               = 1'b1;
      end
   end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import u8dec_pkg::*;

   typedef enum logic [1:0] {
      EXP_PREDICTED,
      EXP_NONE,
      EXP_TYPED
   } expect_mode_type;

   typedef struct packed {
      logic [7:0]       data;
      logic             fin;
      expect_mode_type  mode;
      u8dec_result_type want;
   } stim_row_type;

   // directed strings: extremes, each error class, dropping after an error
   localparam stim_row_type DIRECTED_ROWS [26] = '{
      '{8'h00, 1'b1, EXP_TYPED, '{21'h000000, KIND_VALID, 1'b1}},
      '{8'h7F, 1'b0, EXP_TYPED, '{21'h00007F, KIND_VALID, 1'b0}},
      // stray continuation as lead, rest of string dropped
      '{8'h80, 1'b0, EXP_TYPED, '{21'h000000, KIND_INVALID, 1'b1}},
      '{8'h41, 1'b1, EXP_NONE, '0},
      // bad lead on the final byte goes straight back to idle
      '{8'hC1, 1'b1, EXP_TYPED, '{21'h000000, KIND_INVALID, 1'b1}},
      '{8'hC2, 1'b0, EXP_PREDICTED, '0},
      '{8'h80, 1'b0, EXP_PREDICTED, '0},
      // ASCII where a continuation belongs is consumed, not decoded again
      '{8'hDF, 1'b0, EXP_NONE, '0},
      '{8'h41, 1'b1, EXP_TYPED, '{21'h000000, KIND_INVALID, 1'b1}},
      '{8'hF4, 1'b0, EXP_NONE, '0},
      '{8'h8F, 1'b0, EXP_NONE, '0},
      '{8'hBF, 1'b0, EXP_NONE, '0},
      '{8'hBF, 1'b1, EXP_TYPED, '{21'h10FFFF, KIND_VALID, 1'b1}},
      // truncated by the end of the string
      '{8'hE2, 1'b0, EXP_NONE, '0},
      '{8'h82, 1'b1, EXP_TYPED, '{21'h000000, KIND_INVALID, 1'b1}},
      // overlong
      '{8'hE0, 1'b0, EXP_NONE, '0},
      '{8'h80, 1'b0, EXP_NONE, '0},
      '{8'h80, 1'b1, EXP_TYPED, '{21'h000000, KIND_INVALID, 1'b1}},
      // surrogate, then drop through the final byte
      '{8'hED, 1'b0, EXP_NONE, '0},
      '{8'hA0, 1'b0, EXP_NONE, '0},
      '{8'h80, 1'b0, EXP_TYPED, '{21'h000000, KIND_INVALID, 1'b1}},
      '{8'hFF, 1'b1, EXP_NONE, '0},
      // above the scalar limit
      '{8'hF4, 1'b0, EXP_NONE, '0},
      '{8'h90, 1'b0, EXP_NONE, '0},
      '{8'h80, 1'b0, EXP_NONE, '0},
      '{8'h80, 1'b1, EXP_TYPED, '{21'h000000, KIND_INVALID, 1'b1}}
   };

   localparam logic [POINT_W-1:0] BOUNDARY_POINTS [10] = '{
      21'h000000, 21'h00007F, 21'h000080, 21'h0007FF, 21'h000800,
      21'h00D7FF, 21'h00E000, 21'h00FFFF, 21'h010000, 21'h10FFFF
   };

   logic clock = 1'b0;
   logic reset;

   u8dec_req_if req_bus ();
   u8dec_rsp_if rsp_bus ();

   utf8_validating_decoder DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   u8dec_result_type expected_results[$];
   stim_row_type     byte_stream[$];
   logic [7:0]       seq_bytes[$];
   u8dec_state_type  tracked_state;
   u8dec_state_type  planned_state;
   int unsigned      next_row;
   int unsigned      bytes_accepted;
   int unsigned      live_bytes;
   int unsigned      mismatch_count;
   bit               holding_results;

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic bit reject_string(inout u8dec_state_type st, input logic fin,
                                        output u8dec_result_type res);
      st.bytes_pending   = CONT_NONE;
      st.sequence_length = CONT_NONE;
      st.partial_point   = '0;
      st.discarding      = ~fin;
      res.code_point     = '0;
      res.kind           = KIND_INVALID;
      res.last           = 1'b1;
      return 1'b1;
   endfunction

   // Advances the decoder state by one byte; returns 1 when the byte yields a result.
   function automatic bit decode_byte(inout u8dec_state_type st, input logic [7:0] b,
                                      input logic fin, output u8dec_result_type res);
      logic [POINT_W-1:0] cp;
      bit bad;
      res = '0;
      if (st.discarding) begin
         if (fin)
            st.discarding = 1'b0;
         return 1'b0;
      end
      if (st.bytes_pending == CONT_NONE) begin
         if (b < ASCII_LIMIT) begin
            res.code_point = {13'b0, b};
            res.kind       = KIND_VALID;
            res.last       = fin;
            return 1'b1;
         end
         if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
            st.partial_point   = {16'b0, b[4:0]};
            st.sequence_length = CONT_ONE;
         end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
            st.partial_point   = {17'b0, b[3:0]};
            st.sequence_length = CONT_TWO;
         end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
            st.partial_point   = {18'b0, b[2:0]};
            st.sequence_length = CONT_THREE;
         end else begin
            return reject_string(st, fin, res);
         end
         st.bytes_pending = st.sequence_length;
         if (fin)
            return reject_string(st, fin, res);
         return 1'b0;
      end
      if ((b & CONT_MASK) != CONT_PATTERN)
         return reject_string(st, fin, res);
      st.partial_point = {st.partial_point[POINT_W-7:0], b[5:0]};
      st.bytes_pending = st.bytes_pending - 2'd1;
      if (st.bytes_pending != CONT_NONE) begin
         if (fin)
            return reject_string(st, fin, res);
         return 1'b0;
      end
      cp  = st.partial_point;
      bad = (st.sequence_length == CONT_ONE && cp < MIN_LEN2) ||
            (st.sequence_length == CONT_TWO && cp < MIN_LEN3) ||
            (st.sequence_length == CONT_THREE && cp < MIN_LEN4) ||
            cp > MAX_POINT || (cp >= SURROGATE_LO && cp <= SURROGATE_HI);
      st.bytes_pending   = CONT_NONE;
      st.sequence_length = CONT_NONE;
      st.partial_point   = '0;
      if (bad)
         return reject_string(st, fin, res);
      res.code_point = cp;
      res.kind       = KIND_VALID;
      res.last       = fin;
      return 1'b1;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 65)
         return 0;
      if (r < 93)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int unsigned point_length(logic [POINT_W-1:0] cp);
      if (cp < MIN_LEN2)
         return 1;
      if (cp < MIN_LEN3)
         return 2;
      if (cp < MIN_LEN4)
         return 3;
      return 4;
   endfunction

   task automatic append_point(logic [POINT_W-1:0] cp, int unsigned len);
      case (len)
         1: seq_bytes.push_back({1'b0, cp[6:0]});
         2: begin
            seq_bytes.push_back({3'b110, cp[10:6]});
            seq_bytes.push_back({2'b10, cp[5:0]});
         end
         3: begin
            seq_bytes.push_back({4'b1110, cp[15:12]});
            seq_bytes.push_back({2'b10, cp[11:6]});
            seq_bytes.push_back({2'b10, cp[5:0]});
         end
         default: begin
            seq_bytes.push_back({5'b11110, cp[20:18]});
            seq_bytes.push_back({2'b10, cp[17:12]});
            seq_bytes.push_back({2'b10, cp[11:6]});
            seq_bytes.push_back({2'b10, cp[5:0]});
         end
      endcase
   endtask

   task automatic pick_point(output logic [POINT_W-1:0] cp, output int unsigned len);
      case ($urandom_range(0, 7))
         0, 1, 2: cp = POINT_W'($urandom_range(0, 'h7F));
         3: cp = POINT_W'($urandom_range('h80, 'h7FF));
         4: cp = POINT_W'($urandom_range('h800, 'hFFFF));
         5: cp = POINT_W'($urandom_range('h10000, 'h10FFFF));
         6: cp = BOUNDARY_POINTS[$urandom_range(0, 9)];
         default: cp = POINT_W'($urandom_range(0, 'h10FFFF));
      endcase
      // fold surrogates back into the legal 3-byte range
      if (cp >= SURROGATE_LO && cp <= SURROGATE_HI)
         cp = cp ^ 21'h004000;
      len = point_length(cp);
   endtask

   task automatic append_faulty_point(logic [POINT_W-1:0] cp, int unsigned len);
      int unsigned start;
      int unsigned olen;
      logic [7:0] b;
      if (len == 1) begin
         cp  = POINT_W'($urandom_range('h80, 'h7FF));
         len = 2;
      end
      start = seq_bytes.size();
      case ($urandom_range(0, 5))
         0: begin
            if ($urandom_range(0, 1))
               seq_bytes.push_back(8'($urandom_range('h80, 'hC1)));
            else
               seq_bytes.push_back(8'($urandom_range('hF5, 'hFF)));
         end
         1: begin
            append_point(cp, len);
            b = 8'($urandom_range(0, 255));
            b[6] = 1'b1;
            seq_bytes[start + $urandom_range(1, len - 1)] = b;
         end
         2: begin
            append_point(cp, len);
            repeat ($urandom_range(1, len - 1))
               void'(seq_bytes.pop_back());
         end
         3: begin
            olen = $urandom_range(2, 4);
            if (olen == 2)
               append_point(POINT_W'($urandom_range(0, 'h7F)), olen);
            else if (olen == 3)
               append_point(POINT_W'($urandom_range(0, 'h7FF)), olen);
            else
               append_point(POINT_W'($urandom_range(0, 'hFFFF)), olen);
         end
         4: append_point(POINT_W'($urandom_range('hD800, 'hDFFF)), 3);
         default: append_point(POINT_W'($urandom_range('h110000, 'h1FFFFF)), 4);
      endcase
   endtask

   // Bytes dropped after an error are not counted toward the stimulus length.
   task automatic queue_byte(stim_row_type row);
      u8dec_result_type ignored;
      if (!planned_state.discarding)
         live_bytes++;
      void'(decode_byte(planned_state, row.data, row.fin, ignored));
      byte_stream.push_back(row);
   endtask

   task automatic build_random_string();
      logic [POINT_W-1:0] cp;
      int unsigned len;
      stim_row_type row;
      seq_bytes.delete();
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 6))
            seq_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(1, 6)) begin
            pick_point(cp, len);
            if ($urandom_range(0, 19) == 0)
               append_faulty_point(cp, len);
            else
               append_point(cp, len);
         end
      end
      for (int i = 0; i < seq_bytes.size(); i++) begin
         row      = '0;
         row.data = seq_bytes[i];
         row.fin  = (i == seq_bytes.size() - 1);
         row.mode = EXP_PREDICTED;
         queue_byte(row);
      end
   endtask

   task automatic report_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%s", msg);
   endtask

   task automatic record_transfer(stim_row_type row);
      u8dec_result_type res;
      bit produced;
      bytes_accepted++;
      produced = decode_byte(tracked_state, row.data, row.fin, res);
      case (row.mode)
         EXP_TYPED: expected_results.push_back(row.want);
         EXP_PREDICTED: begin
            if (produced)
               expected_results.push_back(res);
         end
         default: ;
      endcase
   endtask

   // byte sender
   initial begin
      stim_row_type row;
      int unsigned idle_left;
      bit quiet;
      idle_left = 0;
      quiet     = 1'b0;
      row       = '0;
      req_bus.valid      <= 1'b0;
      req_bus.byte_in    <= '0;
      req_bus.final_byte <= 1'b0;
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         if (req_bus.valid && req_bus.ready)
            record_transfer(row);
         if (!req_bus.valid || req_bus.ready) begin
            if (idle_left != 0 && !holding_results) begin
               idle_left--;
               req_bus.valid <= 1'b0;
            end else if (next_row < byte_stream.size()) begin
               row = byte_stream[next_row];
               next_row++;
               req_bus.valid      <= 1'b1;
               req_bus.byte_in    <= row.data;
               req_bus.final_byte <= row.fin;
               if (next_row % 64 == 0)
                  quiet = ($urandom_range(0, 3) == 0);
               idle_left = quiet ? 0 : pick_gap();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
         @(posedge clock);
      end
   end

   // result receiver, with one long hold-off to back up the input
   initial begin
      int unsigned stall_left;
      int unsigned hold_left;
      int unsigned cycles;
      bit quiet;
      bit held;
      stall_left = 0;
      hold_left  = 0;
      cycles     = 0;
      quiet      = 1'b0;
      held       = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles % 128 == 0)
            quiet = ($urandom_range(0, 3) == 0);
         if (!held && bytes_accepted >= 150) begin
            held      = 1'b1;
            hold_left = 300;
         end
         holding_results = (hold_left != 0);
         if (hold_left != 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            stall_left = quiet ? 0 : pick_gap();
         end
      end
   end

   // result checker
   initial begin
      u8dec_result_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("unexpected result: point %h kind %0b last %0b",
                  rsp_bus.code_point, rsp_bus.kind, rsp_bus.last));
            end else begin
               want = expected_results.pop_front();
               if (rsp_bus.code_point !== want.code_point || rsp_bus.kind !== want.kind ||
                   rsp_bus.last !== want.last)
                  report_mismatch($sformatf(
                     "mismatch: expected %h/%0b/%0b, got %h/%0b/%0b",
                     want.code_point, want.kind, want.last,
                     rsp_bus.code_point, rsp_bus.kind, rsp_bus.last));
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      reset           = 1'b1;
      holding_results = 1'b0;
      tracked_state   = '0;
      planned_state   = '0;
      next_row        = 0;
      bytes_accepted  = 0;
      live_bytes      = 0;
      mismatch_count  = 0;
      for (int i = 0; i < $size(DIRECTED_ROWS); i++)
         queue_byte(DIRECTED_ROWS[i]);
      while (live_bytes < 600)
         build_random_string();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      do
         @(posedge clock);
      while (next_row < byte_stream.size() || req_bus.valid);
      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
